// ----- rtl/mtfd_pkg.sv -----
// Package for the multi-tap fractional delay with feedback.
// Sizes, register indexes, controller states, command/status structs, helpers.
// No dependencies.
`default_nettype none
package mtfd_pkg;

  localparam int DEPTH       = 65536;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int TAPS        = 4;
  localparam int TAP_IDX_W   = $clog2(TAPS);
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_W      = 16;
  localparam int DELAY_W     = 24;
  localparam int FRAC_W      = 8;
  localparam int LEN_W       = 17;
  localparam int NTAPS_W     = 3;
  localparam int CFG_ADDR_W  = 8;
  localparam int CFG_DATA_W  = 17;

  // datapath widths
  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int BLEND_W = SAMPLE_BITS + FRAC_W + 2;
  localparam int PROD_W  = BLEND_W + GAIN_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int T_W     = ACC_W - FRAC_W;
  localparam int XD_W    = SAMPLE_BITS + GAIN_W;
  localparam int TF_W    = T_W + GAIN_W;
  localparam int OSUM_W  = T_W + 1;
  localparam int SSUM_W  = TF_W + 1;
  localparam int SAT_W   = SSUM_W - 28;

  localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_TAPS = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_LINE_LENGTH = CFG_ADDR_W'(1);

  localparam logic [NTAPS_W-1:0] ACTIVE_TAPS_RST = NTAPS_W'(1);
  localparam logic [LEN_W-1:0]   LINE_LENGTH_RST = LEN_W'(48000);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic signed [GAIN_W-1:0]      dry_gain;
    logic signed [GAIN_W-1:0]      feedback_gain;
    logic [TAPS-1:0][DELAY_W-1:0]  tap_delay;
    logic [TAPS-1:0][GAIN_W-1:0]   tap_gain;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAP,
    S_RD_HI,
    S_BLEND,
    S_PROD,
    S_ACC,
    S_FIN_T,
    S_FIN_M,
    S_FIN_W
  } state_t;

  typedef struct packed {
    logic load_item;
    logic tap_next;
    logic rd_lo;
    logic rd_hi;
    logic blend;
    logic prod;
    logic acc_add;
    logic fin_t;
    logic fin_m;
    logic fin_w;
  } cmd_t;

  typedef struct packed {
    logic taps_zero;
    logic tap_ok;
    logic tap_last;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic                          hit;
    logic signed [SAMPLE_BITS-1:0] val;
  } sat_t;

  // clamp to the signed sample range
  function automatic sat_t sat_sample(input logic signed [SAT_W-1:0] x);
    sat_t r;
    r.hit = 1'b0;
    r.val = SAMPLE_BITS'(x);
    if (x > SAT_W'(2**(SAMPLE_BITS-1) - 1)) begin
      r.hit = 1'b1;
      r.val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (x < -SAT_W'(2**(SAMPLE_BITS-1))) begin
      r.hit = 1'b1;
      r.val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mtfd_in_if.sv -----
// Input item channel: valid/ready plus the item fields.
// Depends on mtfd_pkg.
`default_nettype none
interface mtfd_in_if;
  import mtfd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic signed [GAIN_W-1:0]      dry_gain;
  logic signed [GAIN_W-1:0]      feedback_gain;
  logic [DELAY_W-1:0]            tap0_delay;
  logic signed [GAIN_W-1:0]      tap0_gain;
  logic [DELAY_W-1:0]            tap1_delay;
  logic signed [GAIN_W-1:0]      tap1_gain;
  logic [DELAY_W-1:0]            tap2_delay;
  logic signed [GAIN_W-1:0]      tap2_gain;
  logic [DELAY_W-1:0]            tap3_delay;
  logic signed [GAIN_W-1:0]      tap3_gain;

  modport source (output valid, in_sample, dry_gain, feedback_gain, tap0_delay, tap0_gain,
                  tap1_delay, tap1_gain, tap2_delay, tap2_gain, tap3_delay, tap3_gain,
                  input ready);
  modport sink (input valid, in_sample, dry_gain, feedback_gain, tap0_delay, tap0_gain,
                tap1_delay, tap1_gain, tap2_delay, tap2_gain, tap3_delay, tap3_gain,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/mtfd_out_if.sv -----
// Result channel: valid/ready plus the result fields.
// Depends on mtfd_pkg.
`default_nettype none
interface mtfd_out_if;
  import mtfd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          clipped;

  modport source (output valid, out_sample, clipped, input ready);
  modport sink (input valid, out_sample, clipped, output ready);
endinterface
`default_nettype wire

// ----- rtl/mtfd_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on mtfd_pkg.
`default_nettype none
interface mtfd_cfg_if;
  import mtfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/multitap_fractional_delay_feedback.sv -----
// Top level: multi-tap fractional delay line with feedback.
// Depends on mtfd_pkg, the channel interfaces, mtfd_ctrl, mtfd_dp, mtfd_ram.
// Per item, each contributing tap runs two line reads, blend, product and accumulate (serial
// MAC); a skipped tap only its range check; then final mix and line write. No new item is
// taken until that write (single line RAM port). A stalled result holds the line write.
// Reset clears state and write pointer; unwritten line entries read as zero by a fill mark.
`default_nettype none
module multitap_fractional_delay_feedback (
  input  wire logic   clk,
  input  wire logic   rst,
  mtfd_in_if.sink     item,
  mtfd_out_if.source  result,
  mtfd_cfg_if.sink    cfg
);
  import mtfd_pkg::*;

  cmd_t                   cmd;
  status_t                status;
  item_t                  item_data;
  logic                   in_ready;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign item.ready = in_ready;
  assign cfg.ready  = 1'b1;

  always_comb begin
    item_data.in_sample     = item.in_sample;
    item_data.dry_gain      = item.dry_gain;
    item_data.feedback_gain = item.feedback_gain;
    item_data.tap_delay[0]  = item.tap0_delay;
    item_data.tap_delay[1]  = item.tap1_delay;
    item_data.tap_delay[2]  = item.tap2_delay;
    item_data.tap_delay[3]  = item.tap3_delay;
    item_data.tap_gain[0]   = item.tap0_gain;
    item_data.tap_gain[1]   = item.tap1_gain;
    item_data.tap_gain[2]   = item.tap2_gain;
    item_data.tap_gain[3]   = item.tap3_gain;
  end

  mtfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mtfd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .item       (item_data),
    .cfg_we     (cfg.valid),
    .cfg_addr   (cfg.addr),
    .cfg_data   (cfg.data),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_sample (result.out_sample),
    .clipped    (result.clipped)
  );

  mtfd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ----- rtl/mtfd_ram.sv -----
// Generic single-port RAM, registered read.
// No dependencies.
`default_nettype none
module mtfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- rtl/mtfd_ctrl.sv -----
// Controller: sequences tap reads, blend, multiply-accumulate and final mix.
// Depends on mtfd_pkg.
`default_nettype none
module mtfd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mtfd_pkg::status_t status,
  output mtfd_pkg::cmd_t         cmd
);
  import mtfd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = status.taps_zero ? S_FIN_T : S_TAP;
        end
      end
      S_TAP: begin
        if (status.tap_ok) begin
          cmd.rd_lo  = 1'b1;
          state_next = S_RD_HI;
        end else if (status.tap_last) begin
          state_next = S_FIN_T;
        end else begin
          cmd.tap_next = 1'b1;
        end
      end
      S_RD_HI: begin
        cmd.rd_hi  = 1'b1;
        state_next = S_BLEND;
      end
      S_BLEND: begin
        cmd.blend  = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        if (status.tap_last) begin
          state_next = S_FIN_T;
        end else begin
          cmd.tap_next = 1'b1;
          state_next   = S_TAP;
        end
      end
      S_FIN_T: begin
        cmd.fin_t  = 1'b1;
        state_next = S_FIN_M;
      end
      S_FIN_M: begin
        cmd.fin_m  = 1'b1;
        state_next = S_FIN_W;
      end
      S_FIN_W: begin
        // wait for the output register to free up
        if (!status.out_busy) begin
          cmd.fin_w  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/mtfd_dp.sv -----
// Datapath: item and config registers, line addressing, blend, MAC, mix,
// saturation and output register. Depends on mtfd_pkg; drives mtfd_ram.
`default_nettype none
module mtfd_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mtfd_pkg::cmd_t                     cmd,
  output mtfd_pkg::status_t                       status,
  input  wire mtfd_pkg::item_t                    item,
  input  wire logic                               cfg_we,
  input  wire logic [mtfd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [mtfd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                    ram_we,
  output logic [mtfd_pkg::ADDR_W-1:0]             ram_addr,
  output logic [mtfd_pkg::SAMPLE_BITS-1:0]        ram_wdata,
  input  wire logic [mtfd_pkg::SAMPLE_BITS-1:0]   ram_rdata,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [mtfd_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                    clipped
);
  import mtfd_pkg::*;

  // config and line state
  logic [NTAPS_W-1:0] active_taps;
  logic [LEN_W-1:0]   line_length;
  logic [ADDR_W-1:0]  write_index;
  logic               wrapped;

  // item and working registers
  item_t                         itm;
  logic [TAP_IDX_W-1:0]          tap_idx;
  logic                          rvalid;
  logic signed [SAMPLE_BITS-1:0] h0;
  logic signed [BLEND_W-1:0]     v;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [T_W-1:0]         t;
  logic signed [XD_W-1:0]        xd;
  logic signed [TF_W-1:0]        tf;
  logic signed [SAMPLE_BITS-1:0] o_val;
  logic                          o_hit;

  logic [NTAPS_W-1:0]            n_taps;
  logic [LEN_W-1:0]              eff_len;
  logic [DELAY_W-1:0]            d;
  logic [ADDR_W-1:0]             k;
  logic [FRAC_W-1:0]             f;
  logic [ADDR_W-1:0]             addr_lo;
  logic [ADDR_W-1:0]             addr_hi;
  logic [ADDR_W-1:0]             rd_addr;
  logic                          rd_written;
  logic signed [SAMPLE_BITS-1:0] h;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [OSUM_W-1:0]      o_sum;
  logic signed [SSUM_W-1:0]      s_sum;
  sat_t                          o_sat;
  sat_t                          s_sat;

  assign n_taps  = (active_taps > NTAPS_W'(TAPS)) ? NTAPS_W'(TAPS) : active_taps;
  assign eff_len = (line_length > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : line_length;
  assign d       = itm.tap_delay[tap_idx];
  assign k       = d[DELAY_W-1:FRAC_W];
  assign f       = d[FRAC_W-1:0];
  assign addr_lo = write_index - k;
  assign addr_hi = write_index - k - ADDR_W'(1);
  assign rd_addr = cmd.rd_hi ? addr_hi : addr_lo;
  // entries never written since reset read as zero
  assign rd_written = wrapped || (rd_addr < write_index);

  assign status.taps_zero = (n_taps == '0);
  assign status.tap_ok    = ((LEN_W'(k) + LEN_W'(1)) <= eff_len);
  assign status.tap_last  = ((NTAPS_W'(tap_idx) + NTAPS_W'(1)) >= n_taps);
  assign status.out_busy  = out_valid && !out_ready;

  assign h    = rvalid ? signed'(ram_rdata) : '0;
  assign diff = DIFF_W'(h) - DIFF_W'(h0);

  assign o_sum = OSUM_W'(xd) + OSUM_W'(t) + OSUM_W'(2**13);
  assign o_sat = sat_sample(SAT_W'(o_sum >>> 14));
  assign s_sum = (SSUM_W'(itm.in_sample) <<< 28) + SSUM_W'(tf) + SSUM_W'(2**27);
  assign s_sat = sat_sample(SAT_W'(s_sum >>> 28));

  assign ram_we    = cmd.fin_w;
  assign ram_addr  = cmd.fin_w ? write_index : rd_addr;
  assign ram_wdata = s_sat.val;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_taps <= ACTIVE_TAPS_RST;
      line_length <= LINE_LENGTH_RST;
      write_index <= '0;
      wrapped     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == CFG_ACTIVE_TAPS) begin
        active_taps <= cfg_data[NTAPS_W-1:0];
      end
      if (cfg_we && cfg_addr == CFG_LINE_LENGTH) begin
        line_length <= cfg_data[LEN_W-1:0];
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.fin_w) begin
        out_valid   <= 1'b1;
        write_index <= write_index + ADDR_W'(1);
        if (write_index == ADDR_W'(DEPTH - 1)) begin
          wrapped <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      itm     <= item;
      tap_idx <= '0;
      acc     <= '0;
    end
    if (cmd.tap_next) begin
      tap_idx <= tap_idx + TAP_IDX_W'(1);
    end
    if (cmd.rd_lo || cmd.rd_hi) begin
      rvalid <= rd_written;
    end
    if (cmd.rd_hi) begin
      h0 <= h;
    end
    if (cmd.blend) begin
      // h(k)*256 + (h(k+1) - h(k))*f
      v <= (BLEND_W'(h0) <<< FRAC_W) + BLEND_W'(diff) * BLEND_W'(signed'({1'b0, f}));
    end
    if (cmd.prod) begin
      prod <= PROD_W'(v) * PROD_W'(signed'(itm.tap_gain[tap_idx]));
    end
    if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.fin_t) begin
      t  <= T_W'((acc + ACC_W'(2**(FRAC_W-1))) >>> FRAC_W);
      xd <= XD_W'(itm.in_sample) * XD_W'(itm.dry_gain);
    end
    if (cmd.fin_m) begin
      tf    <= TF_W'(t) * TF_W'(itm.feedback_gain);
      o_val <= o_sat.val;
      o_hit <= o_sat.hit;
    end
    if (cmd.fin_w) begin
      out_sample <= o_val;
      clipped    <= o_hit || s_sat.hit;
    end
  end

endmodule
`default_nettype wire
